// ===== hw/rtl/arw_pkg.sv =====
// Shared types and constants of the adaptive read-ahead window planner.
package arw_pkg;

   localparam int unsigned POS_W  = 48;
   localparam int unsigned SIZE_W = 32;
   localparam int unsigned WIN_W  = 24;
   localparam int unsigned MEM_W  = 27;

   localparam logic [MEM_W-1:0] MEM_LIMIT_RESET = MEM_W'(67108864);

   typedef enum logic [1:0] {
      FUNC_PREAD = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_SEEK  = 2'd2,
      FUNC_CLOSE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ORIGIN_START   = 2'd0,
      ORIGIN_CURRENT = 2'd1,
      ORIGIN_END     = 2'd2,
      ORIGIN_BAD     = 2'd3
   } origin_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CLOSED  = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ACTION_NONE   = 2'd0,
      ACTION_SERVE  = 2'd1,
      ACTION_DIRECT = 2'd2,
      ACTION_REFILL = 2'd3
   } action_type;

   typedef enum logic {
      CSR_OBJECT_LENGTH = 1'b0,
      CSR_MEMORY_LIMIT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      func_type           func;
      logic [POS_W-1:0]   offset_or_distance;
      logic [SIZE_W-1:0]  request_size;
      origin_type         seek_origin;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      action_type         action;
      logic [POS_W-1:0]   fetch_start;
      logic [SIZE_W-1:0]  fetch_length;
      logic [WIN_W-1:0]   copy_from;
      logic [SIZE_W-1:0]  bytes_served;
   } rsp_item_type;

   typedef struct packed {
      logic [POS_W-1:0]   current_position;
      logic               stream_closed;
      logic [POS_W-1:0]   window_base;
      logic [WIN_W-1:0]   buffered_length;
      logic [WIN_W-1:0]   window_size;
   } win_state_type;

endpackage

// ===== hw/rtl/arw_plan.sv =====
// Per-request decision logic: result and next window state from one request.
module arw_plan #(
   parameter int unsigned INITIAL_WINDOW = 65536,
   parameter int unsigned MAX_WINDOW     = 8388608
) (
   input  arw_pkg::req_item_type          item,
   input  arw_pkg::win_state_type         state,
   input  logic [arw_pkg::POS_W-1:0]      object_length,
   input  logic [arw_pkg::MEM_W-1:0]      memory_limit,
   output arw_pkg::rsp_item_type          result,
   output arw_pkg::win_state_type         next_state
);

   localparam int unsigned PW = arw_pkg::POS_W;
   localparam int unsigned SW = arw_pkg::SIZE_W;
   localparam int unsigned WW = arw_pkg::WIN_W;
   localparam logic [WW-1:0] INIT_W = WW'(INITIAL_WINDOW);
   localparam logic [WW-1:0] MAX_W  = WW'(MAX_WINDOW);
   localparam logic [SW-1:0] MAX_S  = SW'(MAX_WINDOW);

   logic [PW+1:0]  seek_base;
   logic [PW+1:0]  seek_target;
   logic [PW-1:0]  offset;
   logic [PW-1:0]  room;
   logic [SW-1:0]  clip_len;
   logic [PW-1:0]  rel;
   logic [WW-1:0]  buf_left;
   logic           hit;
   logic           continues;
   logic [WW:0]    doubled;
   logic [WW-1:0]  new_size;
   logic [SW-1:0]  fetch_max;
   logic [SW-1:0]  fetch_room;
   logic [SW-1:0]  fetch;

   always_comb begin
      // seek target in two extra bits: bit PW+1 flags negative, bit PW overflow
      case (item.seek_origin)
         arw_pkg::ORIGIN_CURRENT: seek_base = {2'b00, state.current_position};
         arw_pkg::ORIGIN_END:     seek_base = {2'b00, object_length};
         default:                 seek_base = '0;
      endcase
      seek_target = seek_base + {{2{item.offset_or_distance[PW-1]}}, item.offset_or_distance};

      offset    = (item.func == arw_pkg::FUNC_PREAD) ? item.offset_or_distance
                                                     : state.current_position;
      room      = object_length - offset;
      clip_len  = ({{(PW-SW){1'b0}}, item.request_size} < room) ? item.request_size
                                                                 : room[SW-1:0];

      rel       = offset - state.window_base;
      buf_left  = state.buffered_length - rel[WW-1:0];
      hit       = (offset >= state.window_base)
                  && (rel <= {{(PW-WW){1'b0}}, state.buffered_length})
                  && (clip_len <= {{(SW-WW){1'b0}}, buf_left});
      continues = (state.buffered_length != '0)
                  && ({1'b0, offset} == ({1'b0, state.window_base}
                                         + {{(PW-WW+1){1'b0}}, state.buffered_length}));

      doubled   = {state.window_size, 1'b0};
      if (!continues) begin
         new_size = INIT_W;
      end else if (doubled < {1'b0, MAX_W}) begin
         new_size = doubled[WW-1:0];
      end else begin
         new_size = MAX_W;
      end
      fetch_max  = (clip_len > {{(SW-WW){1'b0}}, new_size}) ? clip_len
                                                            : {{(SW-WW){1'b0}}, new_size};
      fetch_room = ({{(PW-SW){1'b0}}, fetch_max} > room) ? room[SW-1:0] : fetch_max;
      fetch      = (fetch_room > {{(SW-arw_pkg::MEM_W){1'b0}}, memory_limit})
                   ? {{(SW-arw_pkg::MEM_W){1'b0}}, memory_limit} : fetch_room;

      result     = '0;
      result.status = arw_pkg::STATUS_OK;
      result.action = arw_pkg::ACTION_NONE;
      next_state = state;

      case (item.func)
         arw_pkg::FUNC_CLOSE: begin
            next_state.stream_closed   = 1'b1;
            next_state.buffered_length = '0;
         end
         arw_pkg::FUNC_SEEK: begin
            if (state.stream_closed) begin
               result.status = arw_pkg::STATUS_CLOSED;
            end else if (item.seek_origin == arw_pkg::ORIGIN_BAD
                         || seek_target[PW+1] || seek_target[PW]) begin
               result.status = arw_pkg::STATUS_INVALID;
            end else begin
               next_state.current_position = seek_target[PW-1:0];
            end
         end
         default: begin
            if (item.func == arw_pkg::FUNC_PREAD && item.offset_or_distance[PW-1]) begin
               result.status = arw_pkg::STATUS_INVALID;
            end else if (state.stream_closed) begin
               result.status = arw_pkg::STATUS_CLOSED;
            end else if (item.request_size == '0 || offset >= object_length) begin
               result.status = arw_pkg::STATUS_OK;
            end else begin
               result.bytes_served = clip_len;
               if (item.func == arw_pkg::FUNC_READ) begin
                  next_state.current_position = state.current_position
                                                + {{(PW-SW){1'b0}}, clip_len};
               end
               if (hit) begin
                  result.action    = arw_pkg::ACTION_SERVE;
                  result.copy_from = rel[WW-1:0];
               end else begin
                  next_state.buffered_length = '0;
                  result.fetch_start = offset;
                  if (clip_len >= MAX_S) begin
                     next_state.window_size = INIT_W;
                     result.action          = arw_pkg::ACTION_DIRECT;
                     result.fetch_length    = clip_len;
                  end else begin
                     next_state.window_size = new_size;
                     if ({{(SW-arw_pkg::MEM_W){1'b0}}, memory_limit} < clip_len) begin
                        result.action       = arw_pkg::ACTION_DIRECT;
                        result.fetch_length = clip_len;
                     end else begin
                        result.action              = arw_pkg::ACTION_REFILL;
                        result.fetch_length        = fetch;
                        next_state.window_base     = offset;
                        next_state.buffered_length = fetch[WW-1:0];
                     end
                  end
               end
            end
         end
      endcase
   end

endmodule

// ===== hw/rtl/adaptive_read_ahead_window_top.sv =====
// Top level of the adaptive read-ahead window planner: ports, registers, state.
//
// Read-ahead planner for one object stream. Each request beat (positional
// read, read-and-advance, seek or close) yields exactly one response beat
// telling the data mover what to do: serve from the buffered window, fetch
// directly, refill the window and serve, or nothing. The window size doubles
// while refills continue the previous window, up to MAX_WINDOW, and drops back
// to INITIAL_WINDOW otherwise; refills are capped by memory_limit. Rate: one
// request per clock sustained while rsp_tready stays high. A request is held
// in the input register, where the decision logic evaluates it against the
// window state, and moves into the response register once that slot is free;
// rsp_tvalid rises as it loads. The window state updates in the same edge
// the response register loads, so the following request already sees it.
// While a response waits, an empty input register still takes one more beat,
// then req_tready stays low until the response is taken.
// Write object_length and memory_limit through the csr port only while idle.
module adaptive_read_ahead_window_top #(
   parameter int unsigned INITIAL_WINDOW = 65536,
   parameter int unsigned MAX_WINDOW     = 8388608
) (
   input  logic          clock,
   input  logic          reset,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [87:0]   req_tdata,   // offset_or_distance[47:0], request_size[79:48],
                                      // seek_origin[81:80], zero fill [87:82]
   input  logic [1:0]    req_tuser,   // func[1:0]
   // response stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // fetch_start[47:0], fetch_length[79:48],
                                      // copy_from[103:80], bytes_served[135:104]
   output logic [3:0]    rsp_tuser,   // status[1:0], action[3:2]
   // configuration writes
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [47:0]   csr_wdata
);

   arw_pkg::req_item_type   req_item;
   arw_pkg::req_item_type   item_ff;
   logic                    item_valid_ff;
   arw_pkg::rsp_item_type   rsp_ff;
   arw_pkg::rsp_item_type   rsp_in;
   logic                    rsp_valid_ff;
   arw_pkg::win_state_type  state_ff;
   arw_pkg::win_state_type  state_in;
   logic [arw_pkg::POS_W-1:0] object_length_ff;
   logic [arw_pkg::MEM_W-1:0] memory_limit_ff;
   logic                    advance;

   // unpack the request beat
   assign req_item.func               = arw_pkg::func_type'(req_tuser);
   assign req_item.offset_or_distance = req_tdata[47:0];
   assign req_item.request_size       = req_tdata[79:48];
   assign req_item.seek_origin        = arw_pkg::origin_type'(req_tdata[81:80]);

   // move the held request into the response register when that slot frees
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   arw_plan #(
      .INITIAL_WINDOW (INITIAL_WINDOW),
      .MAX_WINDOW     (MAX_WINDOW)
   ) u_plan (
      .item          (item_ff),
      .state         (state_ff),
      .object_length (object_length_ff),
      .memory_limit  (memory_limit_ff),
      .result        (rsp_in),
      .next_state    (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff                   <= 1'b0;
         rsp_valid_ff                    <= 1'b0;
         state_ff.current_position       <= '0;
         state_ff.stream_closed          <= 1'b0;
         state_ff.window_base            <= '0;
         state_ff.buffered_length        <= '0;
         state_ff.window_size            <= arw_pkg::WIN_W'(INITIAL_WINDOW);
         object_length_ff                <= '0;
         memory_limit_ff                 <= arw_pkg::MEM_LIMIT_RESET;
      end else begin
         // input register: load on accept, drop when the beat moves on
         if (req_tvalid && req_tready) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         // response register: hold until taken
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (arw_pkg::csr_index_type'(csr_index))
               arw_pkg::CSR_OBJECT_LENGTH: object_length_ff <= csr_wdata;
               arw_pkg::CSR_MEMORY_LIMIT:  memory_limit_ff  <= csr_wdata[arw_pkg::MEM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tuser         = {rsp_ff.action, rsp_ff.status};
   assign rsp_tdata[47:0]   = rsp_ff.fetch_start;
   assign rsp_tdata[79:48]  = rsp_ff.fetch_length;
   assign rsp_tdata[103:80] = rsp_ff.copy_from;
   assign rsp_tdata[135:104] = rsp_ff.bytes_served;

endmodule

// ===== bench/adaptive_read_ahead_window_checker.sv =====
// Scoreboard for the read-ahead window planner: predicts each response beat and compares it.
module adaptive_read_ahead_window_checker #(
   parameter int unsigned INITIAL_WINDOW = 65536,
   parameter int unsigned MAX_WINDOW     = 8388608
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [87:0]   req_tdata,
   input  logic [1:0]    req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [135:0]  rsp_tdata,
   input  logic [3:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [47:0]   csr_wdata,
   output int            outstanding,
   output int            mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [arw_pkg::POS_W-1:0] object_len;
   logic [arw_pkg::MEM_W-1:0] mem_limit;
   logic [arw_pkg::POS_W-1:0] position;
   logic                      closed;
   logic [arw_pkg::POS_W-1:0] win_base;
   logic [arw_pkg::WIN_W-1:0] win_fill;
   logic [arw_pkg::WIN_W-1:0] next_win;

   arw_pkg::rsp_item_type planned_rsp[$];

   // Decide one request against the shadow window state and advance that state.
   function automatic arw_pkg::rsp_item_type plan_request(arw_pkg::req_item_type rq);
      arw_pkg::rsp_item_type r;
      longint       distance;
      longint       origin_pos;
      longint       target;
      logic [63:0]  offs;
      logic [63:0]  room;
      logic [63:0]  rd_len;
      logic [63:0]  fetch;
      logic [63:0]  rel;
      logic [63:0]  grown;
      logic         continues;
      r = '0;
      r.status = arw_pkg::STATUS_OK;
      r.action = arw_pkg::ACTION_NONE;
      distance = {{16{rq.offset_or_distance[47]}}, rq.offset_or_distance};
      if (rq.func == arw_pkg::FUNC_CLOSE) begin
         closed = 1'b1;
         win_fill = '0;
         return r;
      end
      if (rq.func == arw_pkg::FUNC_SEEK) begin
         if (closed) begin
            r.status = arw_pkg::STATUS_CLOSED;
            return r;
         end
         case (rq.seek_origin)
            arw_pkg::ORIGIN_START:   origin_pos = 0;
            arw_pkg::ORIGIN_CURRENT: origin_pos = longint'({16'b0, position});
            arw_pkg::ORIGIN_END:     origin_pos = longint'({16'b0, object_len});
            default: begin
               r.status = arw_pkg::STATUS_INVALID;
               return r;
            end
         endcase
         target = origin_pos + distance;
         if (target < 0 || target > longint'(48'hFFFF_FFFF_FFFF)) begin
            r.status = arw_pkg::STATUS_INVALID;
            return r;
         end
         position = target[arw_pkg::POS_W-1:0];
         return r;
      end
      // reads: the sign check on a positional offset wins over the closed check
      if (rq.func == arw_pkg::FUNC_PREAD && distance < 0) begin
         r.status = arw_pkg::STATUS_INVALID;
         return r;
      end
      if (closed) begin
         r.status = arw_pkg::STATUS_CLOSED;
         return r;
      end
      offs = (rq.func == arw_pkg::FUNC_PREAD) ? {16'b0, rq.offset_or_distance}
                                              : {16'b0, position};
      if (rq.request_size == 0 || offs >= {16'b0, object_len})
         return r;
      room = {16'b0, object_len} - offs;
      rd_len = ({32'b0, rq.request_size} < room) ? {32'b0, rq.request_size} : room;
      if (offs >= {16'b0, win_base}) begin
         rel = offs - {16'b0, win_base};
         if (rel <= {40'b0, win_fill} && rd_len <= {40'b0, win_fill} - rel) begin
            r.action = arw_pkg::ACTION_SERVE;
            r.copy_from = rel[arw_pkg::WIN_W-1:0];
            r.bytes_served = rd_len[arw_pkg::SIZE_W-1:0];
            if (rq.func == arw_pkg::FUNC_READ)
               position = position + rd_len[arw_pkg::POS_W-1:0];
            return r;
         end
      end
      continues = (win_fill != 0) && (offs == {16'b0, win_base} + {40'b0, win_fill});
      win_fill = '0;
      r.fetch_start = offs[arw_pkg::POS_W-1:0];
      r.bytes_served = rd_len[arw_pkg::SIZE_W-1:0];
      if (rd_len >= 64'(MAX_WINDOW)) begin
         next_win = arw_pkg::WIN_W'(INITIAL_WINDOW);
         r.action = arw_pkg::ACTION_DIRECT;
         r.fetch_length = rd_len[arw_pkg::SIZE_W-1:0];
      end else begin
         if (continues) begin
            grown = {39'b0, next_win, 1'b0};
            next_win = (grown < 64'(MAX_WINDOW)) ? grown[arw_pkg::WIN_W-1:0]
                                                 : arw_pkg::WIN_W'(MAX_WINDOW);
         end else begin
            next_win = arw_pkg::WIN_W'(INITIAL_WINDOW);
         end
         fetch = (rd_len > {40'b0, next_win}) ? rd_len : {40'b0, next_win};
         if (fetch > room)
            fetch = room;
         if ({37'b0, mem_limit} < rd_len) begin
            r.action = arw_pkg::ACTION_DIRECT;
            r.fetch_length = rd_len[arw_pkg::SIZE_W-1:0];
         end else begin
            if (fetch > {37'b0, mem_limit})
               fetch = {37'b0, mem_limit};
            win_base = offs[arw_pkg::POS_W-1:0];
            win_fill = fetch[arw_pkg::WIN_W-1:0];
            r.action = arw_pkg::ACTION_REFILL;
            r.fetch_length = fetch[arw_pkg::SIZE_W-1:0];
         end
      end
      if (rq.func == arw_pkg::FUNC_READ)
         position = position + rd_len[arw_pkg::POS_W-1:0];
      return r;
   endfunction

   function automatic int check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want === got)
         return 0;
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      arw_pkg::req_item_type rq;
      arw_pkg::rsp_item_type seen;
      arw_pkg::rsp_item_type want;
      int           errs;
      errs = 0;
      if (reset) begin
         object_len = '0;
         mem_limit = arw_pkg::MEM_LIMIT_RESET;
         position = '0;
         closed = 1'b0;
         win_base = '0;
         win_fill = '0;
         next_win = arw_pkg::WIN_W'(INITIAL_WINDOW);
         planned_rsp.delete();
         mismatches <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == arw_pkg::CSR_OBJECT_LENGTH)
               object_len = csr_wdata;
            else
               mem_limit = csr_wdata[arw_pkg::MEM_W-1:0];
         end
         // retire the response beat first so a same-edge request cannot match it
         if (rsp_tvalid && rsp_tready) begin
            seen.status = arw_pkg::status_type'(rsp_tuser[1:0]);
            seen.action = arw_pkg::action_type'(rsp_tuser[3:2]);
            seen.fetch_start = rsp_tdata[47:0];
            seen.fetch_length = rsp_tdata[79:48];
            seen.copy_from = rsp_tdata[103:80];
            seen.bytes_served = rsp_tdata[135:104];
            if (planned_rsp.size() == 0) begin
               $error("response beat with no request outstanding");
               errs++;
            end else begin
               want = planned_rsp.pop_front();
               errs += check_field("status", 64'(want.status), 64'(seen.status));
               errs += check_field("action", 64'(want.action), 64'(seen.action));
               errs += check_field("fetch_start", 64'(want.fetch_start),
                                   64'(seen.fetch_start));
               errs += check_field("fetch_length", 64'(want.fetch_length),
                                   64'(seen.fetch_length));
               errs += check_field("copy_from", 64'(want.copy_from), 64'(seen.copy_from));
               errs += check_field("bytes_served", 64'(want.bytes_served),
                                   64'(seen.bytes_served));
            end
         end
         if (req_tvalid && req_tready) begin
            rq.func = arw_pkg::func_type'(req_tuser);
            rq.offset_or_distance = req_tdata[47:0];
            rq.request_size = req_tdata[79:48];
            rq.seek_origin = arw_pkg::origin_type'(req_tdata[81:80]);
            planned_rsp.push_back(plan_request(rq));
         end
         mismatches <= mismatches + errs;
      end
      outstanding <= planned_rsp.size();
   end

endmodule

// ===== bench/adaptive_read_ahead_window_top_tb.sv =====
// Testbench top for the read-ahead window planner: stimulus, idling and the verdict.
module adaptive_read_ahead_window_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned INITIAL_WINDOW = 65536;
   localparam int unsigned MAX_WINDOW     = 8388608;
   // generous bound: ~810 beats, well covered even with long stalls
   localparam int CYCLE_LIMIT = 400000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [87:0]   req_tdata;   // offset_or_distance[47:0], request_size[79:48],
                               // seek_origin[81:80], zero fill [87:82]
   logic [1:0]    req_tuser;   // func[1:0]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [135:0]  rsp_tdata;   // fetch_start[47:0], fetch_length[79:48],
                               // copy_from[103:80], bytes_served[135:104]
   logic [3:0]    rsp_tuser;   // status[1:0], action[3:2]
   logic          csr_we;
   logic          csr_index;
   logic [47:0]   csr_wdata;

   int            outstanding;
   int            mismatches;
   int            cycle_count = 0;
   bit            steady_flow = 1'b0;   // when set, neither side idles
   logic [47:0]   object_len_now = '0;  // tracks the programmed object length
   logic [31:0]   stream_size = 32'd4096;

   adaptive_read_ahead_window_top #(
      .INITIAL_WINDOW (INITIAL_WINDOW),
      .MAX_WINDOW     (MAX_WINDOW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   adaptive_read_ahead_window_checker #(
      .INITIAL_WINDOW (INITIAL_WINDOW),
      .MAX_WINDOW     (MAX_WINDOW)
   ) scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: stall at random, except during the steady stretch.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= steady_flow || ($urandom_range(99) >= 38);
      end
   end

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   // Mostly powers of two, so sequential reads land exactly on the window end
   // and the window keeps doubling; the rest hit the large-read and clip paths.
   function automatic logic [31:0] pick_size();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return 32'd1 << $urandom_range(18, 6);
         6:                return 32'd1 << $urandom_range(23, 19);
         7:                return $urandom_range(100000, 1);
         8:                return $urandom;
         default:          return $urandom_range(32'h00FF_FFFF, 32'h007F_0000);
      endcase
   endfunction

   // Offset inside the current object, sometimes page aligned.
   function automatic logic [47:0] pick_inside();
      logic [63:0] r;
      if (object_len_now == 0)
         return '0;
      r = {16'b0, rand48()} % {16'b0, object_len_now};
      if ($urandom_range(1))
         r[11:0] = '0;
      return r[47:0];
   endfunction

   // Present one request beat, idling first at random; hold it until accepted.
   task automatic send_request(input arw_pkg::func_type f, input logic [47:0] distance,
                               input logic [31:0] size, input arw_pkg::origin_type origin);
      while (!steady_flow && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {6'b0, origin, size, distance};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold off until every response has come back, then let
   // the pipeline settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   // Program both registers while the block is idle.
   task automatic set_config(input logic [47:0] obj_len, input logic [26:0] mem_lim);
      drain();
      csr_we <= 1'b1;
      csr_index <= arw_pkg::CSR_OBJECT_LENGTH;
      csr_wdata <= obj_len;
      @(posedge clock);
      csr_index <= arw_pkg::CSR_MEMORY_LIMIT;
      csr_wdata <= {21'b0, mem_lim};
      @(posedge clock);
      csr_we <= 1'b0;
      object_len_now = obj_len;
   endtask

   task automatic random_request(input int close_pct);
      int                  pick;
      logic [47:0]         distance;
      logic [31:0]         size;
      arw_pkg::origin_type origin;
      pick = $urandom_range(99);
      origin = arw_pkg::origin_type'(2'($urandom_range(3)));
      distance = rand48();
      if ($urandom_range(9) == 0)
         stream_size = pick_size();
      size = ($urandom_range(24) == 0) ? '0 : stream_size;
      if (pick < close_pct) begin
         send_request(arw_pkg::FUNC_CLOSE, distance, $urandom, origin);
      end else if (pick < 60) begin
         // sequential stream: the bulk of the traffic
         send_request(arw_pkg::FUNC_READ, distance, size, origin);
      end else if (pick < 78) begin
         case ($urandom_range(3))
            0:       distance = distance | 48'h8000_0000_0000;   // negative offset
            1:       ;                                            // anywhere in the field
            default: distance = pick_inside();
         endcase
         send_request(arw_pkg::FUNC_PREAD, distance, size, origin);
      end else if (pick < 96) begin
         origin = ($urandom_range(19) == 0) ? arw_pkg::ORIGIN_BAD
                                            : arw_pkg::origin_type'(2'($urandom_range(2)));
         case ($urandom_range(4))
            0:       distance = 48'($urandom_range(65536)) - 48'd32768;   // small step
            1:       distance = '0;
            2:       ;
            default: distance = pick_inside();
         endcase
         send_request(arw_pkg::FUNC_SEEK, distance, size, origin);
      end else begin
         send_request(arw_pkg::FUNC_PREAD, pick_inside(), $urandom, origin);
      end
   endtask

   initial begin
      logic [47:0] len_cfg;
      logic [26:0] mem_cfg;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Object length is still zero: every read is empty.
      send_request(arw_pkg::FUNC_READ, '0, 32'd100, arw_pkg::ORIGIN_START);
      set_config(48'd1048576, arw_pkg::MEM_LIMIT_RESET);
      send_request(arw_pkg::FUNC_PREAD, '0, 32'd0, arw_pkg::ORIGIN_START);   // empty read
      send_request(arw_pkg::FUNC_PREAD, 48'h8000_0000_0000, 32'd1,
                   arw_pkg::ORIGIN_START);                                   // negative offset
      send_request(arw_pkg::FUNC_PREAD, 48'h7FFF_FFFF_FFFF, 32'd1,
                   arw_pkg::ORIGIN_START);                                   // past the end
      send_request(arw_pkg::FUNC_READ, '0, 32'd4096, arw_pkg::ORIGIN_START);  // first refill
      send_request(arw_pkg::FUNC_READ, '0, 32'd4096, arw_pkg::ORIGIN_START);  // served
      send_request(arw_pkg::FUNC_PREAD, 48'd65536, 32'd65536,
                   arw_pkg::ORIGIN_START);                                   // continues: doubles
      send_request(arw_pkg::FUNC_PREAD, 48'd8, 32'hFFFF_FFFF,
                   arw_pkg::ORIGIN_START);                                   // clipped at the end
      send_request(arw_pkg::FUNC_SEEK, 48'd5, '0, arw_pkg::ORIGIN_BAD);
      send_request(arw_pkg::FUNC_SEEK, 48'(-1), '0, arw_pkg::ORIGIN_START);  // below zero
      send_request(arw_pkg::FUNC_SEEK, 48'(-100), '0, arw_pkg::ORIGIN_END);
      send_request(arw_pkg::FUNC_READ, '0, 32'd1000, arw_pkg::ORIGIN_START); // clipped to 100
      send_request(arw_pkg::FUNC_SEEK, 48'h7FFF_FFFF_FFFF, '0,
                   arw_pkg::ORIGIN_CURRENT);                                 // past end is fine
      send_request(arw_pkg::FUNC_SEEK, 48'h7FFF_FFFF_FFFF, '0,
                   arw_pkg::ORIGIN_CURRENT);                                 // over the field top
      send_request(arw_pkg::FUNC_SEEK, '0, '0, arw_pkg::ORIGIN_START);
      set_config(48'd1048576, '0);
      send_request(arw_pkg::FUNC_READ, '0, 32'd10, arw_pkg::ORIGIN_START);   // memory short
      set_config(48'hFFFF_FFFF_FFFF, 27'h7FF_FFFF);
      send_request(arw_pkg::FUNC_READ, '0, 32'hFFFF_FFFF, arw_pkg::ORIGIN_START);  // large read
      send_request(arw_pkg::FUNC_READ, '0, MAX_WINDOW, arw_pkg::ORIGIN_START);  // exactly max
      send_request(arw_pkg::FUNC_READ, '0, MAX_WINDOW - 1, arw_pkg::ORIGIN_START);  // below it

      // Random phases, one register setting each; the third runs without idling.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       begin len_cfg = 48'd1 << 30;      mem_cfg = arw_pkg::MEM_LIMIT_RESET; end
            1:       begin len_cfg = 48'hFFFF_FFFF_FFFF;   mem_cfg = 27'h7FF_FFFF;    end
            2:       begin len_cfg = 48'd5000;             mem_cfg = 27'd4096;        end
            3:       begin len_cfg = 48'($urandom_range(32'h0400_0000)); mem_cfg = '0; end
            4:       begin len_cfg = 48'd1 << 24;          mem_cfg = 27'd200000;      end
            default: begin len_cfg = rand48();             mem_cfg = 27'($urandom);   end
         endcase
         set_config(len_cfg, mem_cfg);
         steady_flow = (phase == 2);
         send_request(arw_pkg::FUNC_SEEK, '0, '0, arw_pkg::ORIGIN_START);
         repeat (125) random_request(0);
      end
      steady_flow = 1'b0;

      // Close is permanent, so it comes last: the closed stream's answers,
      // a close on a closed stream, then random traffic with more closes.
      set_config(48'd1 << 20, arw_pkg::MEM_LIMIT_RESET);
      send_request(arw_pkg::FUNC_READ, '0, 32'd4096, arw_pkg::ORIGIN_START);
      send_request(arw_pkg::FUNC_CLOSE, '0, '0, arw_pkg::ORIGIN_START);
      send_request(arw_pkg::FUNC_READ, '0, 32'd4096, arw_pkg::ORIGIN_START);
      send_request(arw_pkg::FUNC_PREAD, 48'd16, 32'd4096, arw_pkg::ORIGIN_START);
      send_request(arw_pkg::FUNC_PREAD, 48'hFFFF_FFFF_FFFF, 32'd4096,
                   arw_pkg::ORIGIN_START);                                   // invalid wins
      send_request(arw_pkg::FUNC_SEEK, '0, '0, arw_pkg::ORIGIN_START);
      send_request(arw_pkg::FUNC_CLOSE, '0, '0, arw_pkg::ORIGIN_START);
      repeat (30) random_request(10);

      drain();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/arw_pkg.sv
hw/rtl/arw_plan.sv
hw/rtl/adaptive_read_ahead_window_top.sv
bench/adaptive_read_ahead_window_checker.sv
bench/adaptive_read_ahead_window_top_tb.sv
